FILE: hdl/lslf_pkg.sv
// shared types, constants and helpers for the least-squares line fit block
`timescale 1ns / 1ps
`default_nettype none

package lslf_pkg;

  // default sizing of the block
  localparam int LSLF_MAX_POINTS    = 4096;
  localparam int LSLF_OUT_FRAC_BITS = 16;

  // width of the shared arithmetic datapath
  localparam int WIDE = 128;

  // fixed scale of the determination quotient
  localparam logic [6:0] SH_DET = 7'd16;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FEW    = 2'd1;
  localparam logic [1:0] ST_XCONST = 2'd2;
  localparam logic [1:0] ST_YCONST = 2'd3;

  // shared unit operations
  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  // request to the shared unit
  typedef struct packed {
    logic       start;
    alu_op_t    op;
    logic [6:0] sh;
  } alu_req_t;

  // response from the shared unit
  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  // sequencer steps
  typedef enum logic [5:0] {
    S_IDLE,
    M_NXX,
    M_XX,
    M_NYY,
    M_YY,
    M_NXY,
    M_XY,
    D_SLOPE,
    M_P,
    M_Q,
    M_NA,
    D_OFF,
    M_C2,
    D_G,
    D_DET,
    M_AB,
    D_V,
    M_ND,
    D_RS,
    Q_RS,
    M_AD,
    D_SE,
    Q_SE,
    M_VX,
    D_U,
    D_IE,
    Q_IE,
    M_GD,
    D_T,
    Q_T,
    S_DONE
  } step_t;

  // sign and magnitude to saturated signed 32 bits
  function automatic logic [31:0] to_s32(input logic neg, input logic [WIDE-1:0] m);
    logic [31:0] r;
    if (neg) begin
      if ((m[WIDE-1:32] != '0) || (m[31:0] > 32'h8000_0000)) r = 32'h8000_0000;
      else r = 32'd0 - m[31:0];
    end else begin
      if (m[WIDE-1:31] != '0) r = 32'h7FFF_FFFF;
      else r = m[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lslf_accum.sv
// running sums of count, x, y, xy, xx and yy over one set of pairs
`timescale 1ns / 1ps
`default_nettype none

module lslf_accum #(
  parameter int MAX_POINTS = lslf_pkg::LSLF_MAX_POINTS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  add,
  input  wire logic                                  clear,
  input  wire logic signed [15:0]                    x_in,
  input  wire logic signed [15:0]                    y_in,
  output logic [$clog2(MAX_POINTS+1)-1:0]            count,
  output logic signed [16+$clog2(MAX_POINTS+1)-1:0]  sum_x,
  output logic signed [16+$clog2(MAX_POINTS+1)-1:0]  sum_y,
  output logic signed [31+$clog2(MAX_POINTS+1)-1:0]  sum_xy,
  output logic [30+$clog2(MAX_POINTS+1)-1:0]         sum_xx,
  output logic [30+$clog2(MAX_POINTS+1)-1:0]         sum_yy
);

  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int XS_W = 16 + CW;
  localparam int XY_W = 31 + CW;
  localparam int XX_W = 30 + CW;

  logic signed [31:0] pxy;
  logic signed [31:0] pxx;
  logic signed [31:0] pyy;
  logic               room;

  // products of the incoming pair
  assign pxy  = x_in * y_in;
  assign pxx  = x_in * x_in;
  assign pyy  = y_in * y_in;
  assign room = (count < CW'(MAX_POINTS));

  // accumulate while the set has room, clear once the fit is handed off
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count  <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xy <= '0;
      sum_xx <= '0;
      sum_yy <= '0;
    end else if (add && room) begin
      count  <= count + CW'(1);
      sum_x  <= sum_x + XS_W'(x_in);
      sum_y  <= sum_y + XS_W'(y_in);
      sum_xy <= sum_xy + XY_W'(pxy);
      sum_xx <= sum_xx + XX_W'(pxx[30:0]);
      sum_yy <= sum_yy + XX_W'(pyy[30:0]);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lslf_alu.sv
// shared iterative unit: 64x64 multiply, scaled restoring divide, floor square root
`timescale 1ns / 1ps
`default_nettype none

module lslf_alu (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire lslf_pkg::alu_req_t         req,
  input  wire logic [lslf_pkg::WIDE-1:0]  a,
  input  wire logic [lslf_pkg::WIDE-1:0]  b,
  output lslf_pkg::alu_rsp_t              rsp,
  output logic [lslf_pkg::WIDE-1:0]       res
);

  lslf_pkg::alu_op_t op;
  logic              busy;
  logic              done;
  logic [7:0]        cnt;
  logic              last_iter;

  logic              sat;
  logic [63:0]       ma;
  logic [63:0]       mb;
  logic [127:0]      acc;
  logic [127:0]      dq;
  logic [128:0]      rem;
  logic [127:0]      den;
  logic [30:0]       root;

  logic [79:0]       partial;
  logic [127:0]      acc_next;
  logic [128:0]      rem_s;
  logic              ge;
  logic [128:0]      rem_d;
  logic [34:0]       srem_s;
  logic [34:0]       trial;
  logic              sge;
  logic [34:0]       srem_d;

  // end of each operation
  always_comb begin
    case (op)
      lslf_pkg::ALU_MUL:  last_iter = (cnt == 8'd3);
      lslf_pkg::ALU_DIV:  last_iter = (cnt == 8'd127);
      lslf_pkg::ALU_SQRT: last_iter = (cnt == 8'd30);
      default:            last_iter = 1'b1;
    endcase
  end

  // multiply: one 64x16 partial product a cycle
  assign partial  = {16'd0, ma} * {64'd0, mb[15:0]};
  assign acc_next = acc + (128'(partial) << {cnt[1:0], 4'b0000});

  // divide: one quotient bit a cycle
  assign rem_s = {rem[127:0], dq[127]};
  assign ge    = (rem_s >= {1'b0, den});
  assign rem_d = ge ? (rem_s - {1'b0, den}) : rem_s;

  // square root: one root bit a cycle
  assign srem_s = {rem[32:0], dq[127:126]};
  assign trial  = {2'b00, root, 2'b01};
  assign sge    = (srem_s >= trial);
  assign srem_d = sge ? (srem_s - trial) : srem_s;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= lslf_pkg::ALU_MUL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op   <= req.op;
      end else if (busy) begin
        cnt <= cnt + 8'd1;
        if (last_iter) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      case (req.op)
        lslf_pkg::ALU_MUL: begin
          ma  <= a[63:0];
          mb  <= b[63:0];
          acc <= '0;
        end
        lslf_pkg::ALU_DIV: begin
          sat <= (b == '0) ||
                 ((a != '0) && ((a >> (8'd127 - {1'b0, req.sh})) != '0));
          dq  <= a << req.sh;
          rem <= '0;
          den <= b;
        end
        lslf_pkg::ALU_SQRT: begin
          sat  <= (a[127:62] != '0);
          dq   <= {a[61:0], 66'd0};
          rem  <= '0;
          root <= '0;
        end
        default: begin
          acc <= '0;
        end
      endcase
    end else if (busy) begin
      case (op)
        lslf_pkg::ALU_MUL: begin
          acc <= acc_next;
          mb  <= mb >> 16;
        end
        lslf_pkg::ALU_DIV: begin
          rem <= rem_d;
          dq  <= {dq[126:0], ge};
        end
        lslf_pkg::ALU_SQRT: begin
          rem  <= 129'(srem_d[32:0]);
          dq   <= dq << 2;
          root <= {root[29:0], sge};
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  // result select
  always_comb begin
    case (op)
      lslf_pkg::ALU_MUL:  res = acc;
      lslf_pkg::ALU_DIV:  res = sat ? {128{1'b1}} : dq;
      lslf_pkg::ALU_SQRT: res = sat ? 128'h7FFF_FFFF : 128'(root);
      default:            res = acc;
    endcase
  end

  assign rsp.busy = busy;
  assign rsp.done = done;

endmodule

`default_nettype wire

FILE: hdl/least_squares_line_fit_core.sv
// top level of the least-squares line fit: accumulator, fit sequencer, result register
//
// Input channel: one (x_value, y_value, last) beat per accepted pair, taken when
// in_valid is high and in_stall is low. Pairs are summed into registered running
// sums, so inside a set one beat is accepted every cycle. A set holds at most
// MAX_POINTS pairs; further pairs are dropped until a beat with last set.
// The beat with last set starts the fit. in_stall stays high for the whole fit,
// which runs through one shared multiply/divide/root unit under a step sequencer.
// When there are fewer than two points or x is constant, the fit stops after the
// multiply steps on the raw sums.
// Output channel: one result beat per set, held in an output register until
// taken (out_valid high, out_stall low). While the receiver stalls, the fit of
// the next set waits at its end and the input stays stalled; the running sums
// are cleared when the result is loaded into the output register.
// Reset (rst, synchronous) clears the sums, the sequencer and out_valid.
`timescale 1ns / 1ps
`default_nettype none

module least_squares_line_fit_core #(
  parameter int MAX_POINTS    = lslf_pkg::LSLF_MAX_POINTS,
  parameter int OUT_FRAC_BITS = lslf_pkg::LSLF_OUT_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] x_value,
  input  wire logic signed [15:0] y_value,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      slope,
  output logic signed [31:0]      offset,
  output logic [16:0]             determination,
  output logic [30:0]             resid_sd,
  output logic [30:0]             slope_err,
  output logic [30:0]             icept_err,
  output logic signed [31:0]      t_stat,
  output logic [12:0]             point_count,
  output logic [11:0]             freedom,
  output logic [1:0]              status,
  output logic                    errors_valid
);

  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int XS_W = 16 + CW;
  localparam int XY_W = 31 + CW;
  localparam int XX_W = 30 + CW;
  localparam int W    = lslf_pkg::WIDE;

  localparam logic [6:0] SH_F    = 7'(OUT_FRAC_BITS);
  localparam logic [6:0] SH_F8   = 7'(OUT_FRAC_BITS - 8);
  localparam logic [6:0] SH_2F16 = 7'(2 * OUT_FRAC_BITS - 16);
  localparam logic [6:0] SH_2F   = 7'(2 * OUT_FRAC_BITS);

  lslf_pkg::step_t    step;
  lslf_pkg::step_t    step_next;
  lslf_pkg::alu_req_t alu_req;
  lslf_pkg::alu_rsp_t alu_rsp;
  logic [W-1:0]       alu_a;
  logic [W-1:0]       alu_b;
  logic [W-1:0]       alu_res;
  logic               is_op;
  logic               issued;
  logic               step_done;

  logic                   in_fire;
  logic                   load;
  logic [CW-1:0]          count;
  logic signed [XS_W-1:0] sum_x;
  logic signed [XS_W-1:0] sum_y;
  logic signed [XY_W-1:0] sum_xy;
  logic [XX_W-1:0]        sum_xx;
  logic [XX_W-1:0]        sum_yy;

  logic [63:0]   sx64;
  logic [63:0]   sy64;
  logic [63:0]   sxy64;
  logic [63:0]   mag_x;
  logic [63:0]   mag_y;
  logic [63:0]   mag_xy;
  logic [CW-1:0] dof;
  logic [1:0]    st;
  logic          ev;

  // fit working registers
  logic [63:0]  a_reg;
  logic [63:0]  b_reg;
  logic [63:0]  cu;
  logic         negc;
  logic [63:0]  magc;
  logic [W-1:0] t1;
  logic [W-1:0] t2;
  logic [W-1:0] c2;
  logic [W-1:0] g;
  logic [W-1:0] v;
  logic [W-1:0] nd;
  logic         negn;
  logic [W-1:0] res_neg;
  logic [W-1:0] t1_sub;
  logic [W-1:0] xy_sub;

  // offset numerator terms
  logic         negp;
  logic         negq;

  // fit results
  logic [31:0] r_slope;
  logic [31:0] r_offset;
  logic [16:0] r_det;
  logic [30:0] r_rsd;
  logic [30:0] r_se;
  logic [30:0] r_ie;
  logic [31:0] r_t;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (step != lslf_pkg::S_IDLE);
  assign load     = (step == lslf_pkg::S_DONE) && (!out_valid || !out_stall);

  lslf_accum #(
    .MAX_POINTS(MAX_POINTS)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .add    (in_fire),
    .clear  (load),
    .x_in   (x_value),
    .y_in   (y_value),
    .count  (count),
    .sum_x  (sum_x),
    .sum_y  (sum_y),
    .sum_xy (sum_xy),
    .sum_xx (sum_xx),
    .sum_yy (sum_yy)
  );

  lslf_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (alu_a),
    .b   (alu_b),
    .rsp (alu_rsp),
    .res (alu_res)
  );

  // magnitudes of the signed sums
  assign sx64   = {{(64 - XS_W){sum_x[XS_W-1]}}, sum_x};
  assign sy64   = {{(64 - XS_W){sum_y[XS_W-1]}}, sum_y};
  assign sxy64  = {{(64 - XY_W){sum_xy[XY_W-1]}}, sum_xy};
  assign mag_x  = sx64[63] ? (64'd0 - sx64) : sx64;
  assign mag_y  = sy64[63] ? (64'd0 - sy64) : sy64;
  assign mag_xy = sxy64[63] ? (64'd0 - sxy64) : sxy64;

  // degrees of freedom and status
  assign dof = (count >= CW'(2)) ? (count - CW'(2)) : '0;

  always_comb begin
    if (count < CW'(2)) st = lslf_pkg::ST_FEW;
    else if (a_reg == '0) st = lslf_pkg::ST_XCONST;
    else if (b_reg == '0) st = lslf_pkg::ST_YCONST;
    else st = lslf_pkg::ST_OK;
  end

  assign ev = ((st == lslf_pkg::ST_OK) || (st == lslf_pkg::ST_YCONST)) && (dof != '0);

  assign negc    = cu[63];
  assign magc    = negc ? (64'd0 - cu) : cu;
  assign res_neg = '0 - alu_res;
  assign t1_sub  = t1 - alu_res;
  assign xy_sub  = t1 - ((sx64[63] ^ sy64[63]) ? res_neg : alu_res);
  assign negp    = sy64[63];
  assign negq    = (alu_res != '0) && (negc == sx64[63]);

  assign step_done = alu_rsp.done && issued;

  // next step
  always_comb begin
    step_next = step;
    case (step)
      lslf_pkg::S_IDLE:  if (in_fire && last) step_next = lslf_pkg::M_NXX;
      lslf_pkg::S_DONE:  if (!out_valid || !out_stall) step_next = lslf_pkg::S_IDLE;
      lslf_pkg::M_NXX:   if (step_done) step_next = lslf_pkg::M_XX;
      lslf_pkg::M_XX:    if (step_done) step_next = lslf_pkg::M_NYY;
      lslf_pkg::M_NYY:   if (step_done) step_next = lslf_pkg::M_YY;
      lslf_pkg::M_YY:    if (step_done) step_next = lslf_pkg::M_NXY;
      lslf_pkg::M_NXY:   if (step_done) step_next = lslf_pkg::M_XY;
      lslf_pkg::M_XY: begin
        if (step_done) begin
          if ((st == lslf_pkg::ST_FEW) || (st == lslf_pkg::ST_XCONST))
            step_next = lslf_pkg::S_DONE;
          else
            step_next = lslf_pkg::D_SLOPE;
        end
      end
      lslf_pkg::D_SLOPE: if (step_done) step_next = lslf_pkg::M_P;
      lslf_pkg::M_P:     if (step_done) step_next = lslf_pkg::M_Q;
      lslf_pkg::M_Q:     if (step_done) step_next = lslf_pkg::M_NA;
      lslf_pkg::M_NA:    if (step_done) step_next = lslf_pkg::D_OFF;
      lslf_pkg::D_OFF:   if (step_done) step_next = lslf_pkg::M_C2;
      lslf_pkg::M_C2:    if (step_done) step_next = lslf_pkg::D_G;
      lslf_pkg::D_G: begin
        if (step_done) begin
          if (st == lslf_pkg::ST_OK) step_next = lslf_pkg::D_DET;
          else if (ev) step_next = lslf_pkg::M_AB;
          else step_next = lslf_pkg::S_DONE;
        end
      end
      lslf_pkg::D_DET:   if (step_done) step_next = ev ? lslf_pkg::M_AB : lslf_pkg::S_DONE;
      lslf_pkg::M_AB:    if (step_done) step_next = lslf_pkg::D_V;
      lslf_pkg::D_V:     if (step_done) step_next = lslf_pkg::M_ND;
      lslf_pkg::M_ND:    if (step_done) step_next = lslf_pkg::D_RS;
      lslf_pkg::D_RS:    if (step_done) step_next = lslf_pkg::Q_RS;
      lslf_pkg::Q_RS:    if (step_done) step_next = lslf_pkg::M_AD;
      lslf_pkg::M_AD:    if (step_done) step_next = lslf_pkg::D_SE;
      lslf_pkg::D_SE:    if (step_done) step_next = lslf_pkg::Q_SE;
      lslf_pkg::Q_SE:    if (step_done) step_next = lslf_pkg::M_VX;
      lslf_pkg::M_VX:    if (step_done) step_next = lslf_pkg::D_U;
      lslf_pkg::D_U:     if (step_done) step_next = lslf_pkg::D_IE;
      lslf_pkg::D_IE:    if (step_done) step_next = lslf_pkg::Q_IE;
      lslf_pkg::Q_IE: begin
        if (step_done)
          step_next = (st == lslf_pkg::ST_OK) ? lslf_pkg::M_GD : lslf_pkg::S_DONE;
      end
      lslf_pkg::M_GD:    if (step_done) step_next = lslf_pkg::D_T;
      lslf_pkg::D_T:     if (step_done) step_next = lslf_pkg::Q_T;
      lslf_pkg::Q_T:     if (step_done) step_next = lslf_pkg::S_DONE;
      default:           step_next = lslf_pkg::S_IDLE;
    endcase
  end

  // operation and operands of each step
  always_comb begin
    is_op  = 1'b1;
    alu_a  = '0;
    alu_b  = '0;
    alu_req.op = lslf_pkg::ALU_MUL;
    alu_req.sh = 7'd0;
    case (step)
      lslf_pkg::M_NXX: begin alu_a = W'(count); alu_b = W'(sum_xx); end
      lslf_pkg::M_XX:  begin alu_a = W'(mag_x); alu_b = W'(mag_x); end
      lslf_pkg::M_NYY: begin alu_a = W'(count); alu_b = W'(sum_yy); end
      lslf_pkg::M_YY:  begin alu_a = W'(mag_y); alu_b = W'(mag_y); end
      lslf_pkg::M_NXY: begin alu_a = W'(count); alu_b = W'(mag_xy); end
      lslf_pkg::M_XY:  begin alu_a = W'(mag_x); alu_b = W'(mag_y); end
      lslf_pkg::D_SLOPE: begin
        alu_req.op = lslf_pkg::ALU_DIV; alu_req.sh = SH_F;
        alu_a = W'(magc); alu_b = W'(a_reg);
      end
      lslf_pkg::M_P:   begin alu_a = W'(mag_y); alu_b = W'(a_reg); end
      lslf_pkg::M_Q:   begin alu_a = W'(magc); alu_b = W'(mag_x); end
      lslf_pkg::M_NA:  begin alu_a = W'(count); alu_b = W'(a_reg); end
      lslf_pkg::D_OFF: begin
        alu_req.op = lslf_pkg::ALU_DIV; alu_req.sh = SH_F8;
        alu_a = t1; alu_b = t2;
      end
      lslf_pkg::M_C2:  begin alu_a = W'(magc); alu_b = W'(magc); end
      lslf_pkg::D_G: begin
        alu_req.op = lslf_pkg::ALU_DIV;
        alu_a = c2; alu_b = W'(a_reg);
      end
      lslf_pkg::D_DET: begin
        alu_req.op = lslf_pkg::ALU_DIV; alu_req.sh = lslf_pkg::SH_DET;
        alu_a = g; alu_b = W'(b_reg);
      end
      lslf_pkg::M_AB:  begin alu_a = W'(a_reg); alu_b = W'(b_reg); end
      lslf_pkg::D_V: begin
        alu_req.op = lslf_pkg::ALU_DIV;
        alu_a = t1; alu_b = W'(a_reg);
      end
      lslf_pkg::M_ND:  begin alu_a = W'(count); alu_b = W'(dof); end
      lslf_pkg::D_RS: begin
        alu_req.op = lslf_pkg::ALU_DIV; alu_req.sh = SH_2F16;
        alu_a = v; alu_b = nd;
      end
      lslf_pkg::Q_RS:  begin alu_req.op = lslf_pkg::ALU_SQRT; alu_a = t1; end
      lslf_pkg::M_AD:  begin alu_a = W'(a_reg); alu_b = W'(dof); end
      lslf_pkg::D_SE: begin
        alu_req.op = lslf_pkg::ALU_DIV; alu_req.sh = SH_2F;
        alu_a = v; alu_b = t2;
      end
      lslf_pkg::Q_SE:  begin alu_req.op = lslf_pkg::ALU_SQRT; alu_a = t1; end
      lslf_pkg::M_VX:  begin alu_a = W'(v[63:0]); alu_b = W'(sum_xx); end
      lslf_pkg::D_U: begin
        alu_req.op = lslf_pkg::ALU_DIV;
        alu_a = t1; alu_b = W'(a_reg);
      end
      lslf_pkg::D_IE: begin
        alu_req.op = lslf_pkg::ALU_DIV; alu_req.sh = SH_2F16;
        alu_a = t2; alu_b = nd;
      end
      lslf_pkg::Q_IE:  begin alu_req.op = lslf_pkg::ALU_SQRT; alu_a = t1; end
      lslf_pkg::M_GD:  begin alu_a = W'(g[63:0]); alu_b = W'(dof); end
      lslf_pkg::D_T: begin
        alu_req.op = lslf_pkg::ALU_DIV; alu_req.sh = SH_2F;
        alu_a = t1; alu_b = v;
      end
      lslf_pkg::Q_T:   begin alu_req.op = lslf_pkg::ALU_SQRT; alu_a = t2; end
      default:         is_op = 1'b0;
    endcase
    alu_req.start = is_op && !issued;
  end

  // sequencer and output control
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= lslf_pkg::S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (alu_req.start) issued <= 1'b1;
      else if (alu_rsp.done) issued <= 1'b0;
      if (load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // capture of each step's result
  always_ff @(posedge clk) begin
    if (in_fire && last) begin
      r_slope  <= '0;
      r_offset <= '0;
      r_det    <= '0;
      r_rsd    <= '0;
      r_se     <= '0;
      r_ie     <= '0;
      r_t      <= '0;
    end else if (step_done) begin
      case (step)
        lslf_pkg::M_NXX:   t1 <= alu_res;
        lslf_pkg::M_XX:    a_reg <= t1_sub[63:0];
        lslf_pkg::M_NYY:   t1 <= alu_res;
        lslf_pkg::M_YY:    b_reg <= t1_sub[63:0];
        lslf_pkg::M_NXY:   t1 <= sxy64[63] ? res_neg : alu_res;
        lslf_pkg::M_XY:    cu <= xy_sub[63:0];
        lslf_pkg::D_SLOPE: r_slope <= lslf_pkg::to_s32(negc, alu_res);
        lslf_pkg::M_P:     t1 <= alu_res;
        lslf_pkg::M_Q: begin
          // signed difference of the Y*A and C*X terms
          if (negp == negq) begin
            t1 <= t1 + alu_res; negn <= negp;
          end else if (t1 >= alu_res) begin
            t1 <= t1 - alu_res; negn <= negp;
          end else begin
            t1 <= alu_res - t1; negn <= negq;
          end
        end
        lslf_pkg::M_NA:    t2 <= alu_res;
        lslf_pkg::D_OFF:   r_offset <= lslf_pkg::to_s32(negn, alu_res);
        lslf_pkg::M_C2:    c2 <= alu_res;
        lslf_pkg::D_G:     g <= alu_res;
        lslf_pkg::D_DET:   r_det <= (alu_res > W'(65536)) ? 17'd65536 : alu_res[16:0];
        lslf_pkg::M_AB:    t1 <= (alu_res > c2) ? (alu_res - c2) : '0;
        lslf_pkg::D_V:     v <= alu_res;
        lslf_pkg::M_ND:    nd <= alu_res;
        lslf_pkg::D_RS:    t1 <= alu_res;
        lslf_pkg::Q_RS:    r_rsd <= alu_res[30:0];
        lslf_pkg::M_AD:    t2 <= alu_res;
        lslf_pkg::D_SE:    t1 <= alu_res;
        lslf_pkg::Q_SE:    r_se <= alu_res[30:0];
        lslf_pkg::M_VX:    t1 <= alu_res;
        lslf_pkg::D_U:     t2 <= alu_res;
        lslf_pkg::D_IE:    t1 <= alu_res;
        lslf_pkg::Q_IE:    r_ie <= alu_res[30:0];
        lslf_pkg::M_GD:    t1 <= alu_res;
        lslf_pkg::D_T:     t2 <= alu_res;
        lslf_pkg::Q_T:     r_t <= lslf_pkg::to_s32(negc && (alu_res != '0), alu_res);
        default:           t1 <= t1;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      slope         <= r_slope;
      offset        <= r_offset;
      determination <= r_det;
      resid_sd      <= r_rsd;
      slope_err     <= r_se;
      icept_err     <= r_ie;
      t_stat        <= r_t;
      point_count   <= 13'(count);
      freedom       <= 12'(dof);
      status        <= st;
      errors_valid  <= ev;
    end
  end

`ifndef SYNTHESIS
  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> !alu_rsp.busy)
    else $error("shared unit started while busy");

  a_last_starts_fit: assert property (@(posedge clk) disable iff (rst)
    (in_fire && last) |=> (step == lslf_pkg::M_NXX))
    else $error("fit did not start after last beat");

  a_det_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (determination <= 17'd65536))
    else $error("determination out of range");

  a_errors_need_freedom: assert property (@(posedge clk) disable iff (rst)
    (out_valid && errors_valid) |-> (freedom != 12'd0))
    else $error("error terms flagged valid without freedom");
`endif

endmodule

`default_nettype wire
